FILE: hdl/rwc_pkg.sv
`default_nettype none
package rwc_pkg;

  localparam int unsigned COL_W   = 6;
  localparam int unsigned DIR_W   = 9;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned PT_W    = 10;
  localparam int unsigned DIST_W  = 7;
  localparam int unsigned QUO_W   = 11;
  localparam int unsigned DCNT_W  = 4;
  localparam int unsigned MAP_W   = 64;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 40;

  localparam logic [PT_W-1:0]   VIEW_ORIGIN  = 10'd72;
  localparam logic [DIST_W-1:0] STEP_FIRST   = 7'd4;
  localparam logic [DIST_W-1:0] STEP_INC     = 7'd3;
  localparam logic [DIST_W-1:0] STEP_LAST    = 7'd124;
  localparam logic [DIST_W-1:0] NO_HIT_DIST  = 7'd126;
  localparam logic [DIST_W-1:0] BRIGHT_LIMIT = 7'd40;
  localparam logic [QUO_W-1:0]  HEIGHT_NUM   = 11'd1100;
  localparam logic [QUO_W-1:0]  HEIGHT_CAP   = 11'd174;
  localparam logic [7:0]        HORIZON      = 8'd96;
  localparam logic [3:0]        COLOUR_MOD   = 4'd7;
  localparam logic [DCNT_W-1:0] DIV_FIRST    = 4'd10;

  localparam logic [CIDX_W-1:0] REG_MAP0 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MAP1 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MAP2 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MAP3 = 3'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat, start march at step 4
    logic advance;   // next march step
    logic hit;       // latch current step as distance
    logic miss;      // latch no-hit distance
    logic div_step;  // one restoring division bit
    logic out_load;  // capture result into output register
  } rwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic solid;
    logic last_step;
    logic div_last;
  } rwc_sts_t;

endpackage
`default_nettype wire

FILE: hdl/raycast_wall_column_core.sv
// per column: 1 to 41 march steps (one map lookup each), then bit-serial restoring
//   division for the 11 quotient bits, then load and finish
// one column at a time: a new input is taken only once the previous result is in the
//   output register; a waiting result does not block the next input
// reset: synchronous active-low rst_n clears the controller and the wall map
`default_nettype none
module raycast_wall_column_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [rwc_pkg::IN_W-1:0]    in_tdata,   // column_index[5:0], dir_x[14:6], dir_y[23:15]
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [rwc_pkg::OUT_W-1:0]        out_tdata,  // screen_x[7:0], hit_distance[14:8],
                                                       // top_row[21:15], bottom_row[29:22],
                                                       // ink_colour[32:30], bright_flag[33], zero pad
  // wall map write port
  input  wire logic                        cfg_wr_en,
  input  wire logic [rwc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [rwc_pkg::MAP_W-1:0]   cfg_wdata
);

  // command and status between sequencer and datapath
  rwc_pkg::rwc_cmd_t cmd;
  rwc_pkg::rwc_sts_t sts;

  // sequencer: idle -> march until a solid sample or last step -> divide -> output
  rwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath: incremental products, map lookup, divider, result register
  rwc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

FILE: hdl/rwc_ctrl.sv
`default_nettype none
module rwc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output rwc_pkg::rwc_cmd_t   cmd,
  input  wire rwc_pkg::rwc_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARCH,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MARCH;
        end
      end
      ST_MARCH: begin
        if (sts.solid) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_DIV;
        end else if (sts.last_step) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rwc_dpath.sv
`default_nettype none
module rwc_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [rwc_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rwc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [rwc_pkg::MAP_W-1:0]   cfg_wdata,
  input  wire rwc_pkg::rwc_cmd_t           cmd,
  output rwc_pkg::rwc_sts_t                sts,
  output logic [rwc_pkg::OUT_W-1:0]        out_tdata
);

  logic [rwc_pkg::MAP_W-1:0]   map0_r, map1_r, map2_r, map3_r;
  logic [4*rwc_pkg::MAP_W-1:0] map_all;

  logic [7:0]                  sx_r;
  logic [rwc_pkg::PROD_W-1:0]  px_prod_r, py_prod_r;
  logic [rwc_pkg::PROD_W-1:0]  dx_step_r, dy_step_r;
  logic [rwc_pkg::DIST_W-1:0]  st_r, dist_r;
  logic [rwc_pkg::DIST_W-1:0]  rem_r;
  logic [rwc_pkg::QUO_W-1:0]   quo_r;
  logic [rwc_pkg::DCNT_W-1:0]  dcnt_r;
  logic [rwc_pkg::OUT_W-1:0]   out_r;

  logic [rwc_pkg::PROD_W-1:0]  dx_ext, dy_ext;
  logic [rwc_pkg::PROD_W-1:0]  px_rnd, py_rnd;
  logic [rwc_pkg::PT_W-1:0]    px, py;
  logic                        outside;
  logic [7:0]                  map_bit;

  logic [rwc_pkg::DIST_W:0]    shifted, trial;
  logic [rwc_pkg::QUO_W-1:0]   h_cap;
  logic [6:0]                  half;
  logic [6:0]                  top_row;
  logic [7:0]                  bottom_row;
  logic [3:0]                  dgrp, dmod;
  logic [2:0]                  ink;
  logic                        bright;

  assign map_all = {map3_r, map2_r, map1_r, map0_r};

  // sign-extended direction components
  assign dx_ext = {{(rwc_pkg::PROD_W-rwc_pkg::DIR_W){in_tdata[14]}}, in_tdata[14:6]};
  assign dy_ext = {{(rwc_pkg::PROD_W-rwc_pkg::DIR_W){in_tdata[23]}}, in_tdata[23:15]};

  // divide by 128 truncating toward zero: bias negative products first
  assign px_rnd = px_prod_r[rwc_pkg::PROD_W-1] ? px_prod_r + 16'd127 : px_prod_r;
  assign py_rnd = py_prod_r[rwc_pkg::PROD_W-1] ? py_prod_r + 16'd127 : py_prod_r;
  assign px = {px_rnd[rwc_pkg::PROD_W-1], px_rnd[rwc_pkg::PROD_W-1:7]} + rwc_pkg::VIEW_ORIGIN;
  assign py = {py_rnd[rwc_pkg::PROD_W-1], py_rnd[rwc_pkg::PROD_W-1:7]} + rwc_pkg::VIEW_ORIGIN;

  assign outside = (px[9:8] != 2'b00) || (py[9:8] != 2'b00);
  assign map_bit = {py[7:4], px[7:4]};

  assign sts.solid     = outside || map_all[map_bit];
  assign sts.last_step = (st_r == rwc_pkg::STEP_LAST);
  assign sts.div_last  = (dcnt_r == '0);

  // restoring division of the height constant by the distance
  assign shifted = {rem_r, rwc_pkg::HEIGHT_NUM[dcnt_r]};
  assign trial   = shifted - {1'b0, dist_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map0_r <= '0;
      map1_r <= '0;
      map2_r <= '0;
      map3_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rwc_pkg::REG_MAP0: map0_r <= cfg_wdata;
        rwc_pkg::REG_MAP1: map1_r <= cfg_wdata;
        rwc_pkg::REG_MAP2: map2_r <= cfg_wdata;
        rwc_pkg::REG_MAP3: map3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r      <= {in_tdata[5:0], 2'b10};
      px_prod_r <= dx_ext << 2;
      py_prod_r <= dy_ext << 2;
      dx_step_r <= dx_ext + (dx_ext << 1);
      dy_step_r <= dy_ext + (dy_ext << 1);
      st_r      <= rwc_pkg::STEP_FIRST;
    end else if (cmd.advance) begin
      px_prod_r <= px_prod_r + dx_step_r;
      py_prod_r <= py_prod_r + dy_step_r;
      st_r      <= st_r + rwc_pkg::STEP_INC;
    end
    if (cmd.hit || cmd.miss) begin
      dist_r <= cmd.hit ? st_r : rwc_pkg::NO_HIT_DIST;
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= rwc_pkg::DIV_FIRST;
    end else if (cmd.div_step) begin
      if (!trial[rwc_pkg::DIST_W]) begin
        rem_r <= trial[rwc_pkg::DIST_W-1:0];
        quo_r <= {quo_r[rwc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[rwc_pkg::DIST_W-1:0];
        quo_r <= {quo_r[rwc_pkg::QUO_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 4'd1;
    end
    if (cmd.out_load) begin
      out_r <= {6'd0, bright, ink, bottom_row, top_row, dist_r, sx_r};
    end
  end

  always_comb begin
    h_cap      = (quo_r > rwc_pkg::HEIGHT_CAP) ? rwc_pkg::HEIGHT_CAP : quo_r;
    half       = h_cap[7:1];
    top_row    = 7'(rwc_pkg::HORIZON - {1'b0, half});
    bottom_row = rwc_pkg::HORIZON + {1'b0, half};
    dgrp       = dist_r[6:3];
    if (dgrp >= 4'(2 * rwc_pkg::COLOUR_MOD)) begin
      dmod = dgrp - 4'(2 * rwc_pkg::COLOUR_MOD);
    end else if (dgrp >= rwc_pkg::COLOUR_MOD) begin
      dmod = dgrp - rwc_pkg::COLOUR_MOD;
    end else begin
      dmod = dgrp;
    end
    ink    = dmod[2:0] + 3'd1;
    bright = (dist_r < rwc_pkg::BRIGHT_LIMIT);
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire
